### hw/rtl/silu_activation_and_gradient_macros.svh
// assertion shorthands for the checker of this block
`ifndef SILU_ACTIVATION_AND_GRADIENT_MACROS_SVH
`define SILU_ACTIVATION_AND_GRADIENT_MACROS_SVH

// same-cycle implication, quiet while in reset
`define SILU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("silu check failed");

// next-cycle implication, quiet while in reset
`define SILU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("silu check failed");

// what must hold in the cycle after a reset edge
`define SILU_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("silu reset check failed");

`endif

### hw/rtl/silu_pkg.sv
package silu_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 10;
  localparam int TABLE_BITS = 8;

  // sigmoid in unsigned q0.16, one extra bit so that 1.0 fits
  localparam int SIG_W = 17;
  localparam int ROM_W = 16;
  localparam logic [SIG_W-1:0] ONE_Q16 = SIG_W'(65536);
  // s*(1-s) peaks at 2^30
  localparam int SD_W = 31;
  // derivative in q.16, magnitude below 3.0
  localparam int DQ_W = 20;

  // restoring long division for the table build, quotient of num by den
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigmoid(k*8/2^tb) in q0.16 from an integer exp series, evaluated at elaboration
  function automatic logic [ROM_W-1:0] sig_entry(input int tb, input int k);
    logic [63:0] h;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] q;
    h    = 64'd1 << (35 - tb);
    sum  = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int n = 1; n <= 14; n++) begin
      term = udiv64((term * h) >> 32, 64'(n));
      if ((n & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    e = 64'd1 << 32;
    for (int j = 0; j < k; j++) begin
      e = (e * sum + (64'd1 << 31)) >> 32;
    end
    den = (64'd1 << 32) + e;
    q   = udiv64((64'd1 << 48) + (den >> 1), den);
    return q[ROM_W-1:0];
  endfunction

endpackage

### hw/rtl/silu_if.sv
interface silu_in_if #(
  parameter int DATA_WIDTH = silu_pkg::DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] x_value;
  logic signed [DATA_WIDTH-1:0] upstream_grad;
  logic                         is_last;

  modport source (output valid, output x_value, output upstream_grad, output is_last,
                  input ready);
  modport sink   (input valid, input x_value, input upstream_grad, input is_last,
                  output ready);
endinterface

interface silu_out_if #(
  parameter int DATA_WIDTH = silu_pkg::DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result;
  logic                         saturated;
  logic                         is_last_out;

  modport source (output valid, output result, output saturated, output is_last_out,
                  input ready);
  modport sink   (input valid, input result, input saturated, input is_last_out,
                  output ready);
endinterface

interface silu_cfg_if;
  logic valid;
  logic ready;
  logic mode;

  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface

### hw/rtl/silu_activation_and_gradient.sv
// SiLU activation and its input gradient on signed fixed point (Q5.10 by default).
// in_bus carries x_value, upstream_grad and is_last; out_bus returns result,
// saturated and is_last_out. Both use valid/ready: a beat moves on valid & ready.
// cfg_bus writes the mode bit (0 forward x*s, 1 gradient) and is always ready;
// write it only while no beat is in flight.
// A beat accepted on in_bus is loaded into stage a, passes stages b to f
// (six pipeline stages in all), then the output register, and shows on out_bus.
// Throughput is one beat per cycle while out_bus.ready stays high.
// Sigmoid comes from a constant table of 2^TABLE_BITS entries over |x| < 8.
// Reset clears every valid bit and sets forward mode; the table needs no fill.
// When out_bus.ready is low the result stays put, stages behind it keep
// closing up empty slots, and in_bus.ready drops only once all stages are full.
module silu_activation_and_gradient #(
  parameter int DATA_WIDTH = silu_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = silu_pkg::FRAC_BITS,
  parameter int TABLE_BITS = silu_pkg::TABLE_BITS
) (
  input logic        clk,
  input logic        rst_n,
  silu_in_if.sink    in_bus,
  silu_out_if.source out_bus,
  silu_cfg_if.sink   cfg_bus
);

  localparam int DW    = DATA_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int TB    = TABLE_BITS;
  localparam int TSIZE = 1 << TB;
  localparam int SH    = FB + 3 - TB;
  localparam int CW    = (DW > FB + 4) ? DW : FB + 4;
  localparam int MW    = CW + TB;
  localparam int S_W   = silu_pkg::SIG_W;
  localparam int R_W   = silu_pkg::ROM_W;
  localparam int SD_W  = silu_pkg::SD_W;
  localparam int DQ_W  = silu_pkg::DQ_W;
  localparam int PF_W  = DW + S_W + 1;
  localparam int XSD_W = DW + SD_W + 1;
  localparam int SS_W  = FB + S_W + 17;
  localparam int D_W   = ((XSD_W > SS_W) ? XSD_W : SS_W) + 1;
  localparam int RW    = D_W;
  localparam int P_W   = DQ_W + DW;
  localparam int YF_W  = PF_W - 16;
  localparam int YG_W  = P_W - 16;
  localparam int NS    = 6;

  localparam logic [S_W-1:0] ONE = silu_pkg::ONE_Q16;
  localparam logic [MW-1:0]  LIM = MW'(8) << FB;
  localparam logic signed [YG_W-1:0] MAXV = {{(YG_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [YG_W-1:0] MINV = {{(YG_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

  // round to nearest, ties away from zero
  function automatic logic signed [RW-1:0] rnd_shift(input logic signed [RW-1:0] v,
                                                      input int sh);
    logic [RW-1:0] m;
    logic [RW-1:0] r;
    m = v[RW-1] ? -v : v;
    r = (m + (RW'(1) << (sh - 1))) >> sh;
    return v[RW-1] ? -r : r;
  endfunction

  logic [R_W-1:0] sig_rom [TSIZE];

  for (genvar k = 0; k < TSIZE; k++) begin : g_rom
    localparam logic [R_W-1:0] ENT = silu_pkg::sig_entry(TB, k);
    assign sig_rom[k] = ENT;
  end

  logic          mode_r;
  logic [NS-1:0] vld_r;
  logic          ov_r;
  logic [NS:0]   adv;

  always_comb begin
    adv[NS] = !ov_r || out_bus.ready;
    for (int i = NS - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_bus.ready  = adv[0];
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ov_r   <= 1'b0;
      mode_r <= 1'b0;
    end else begin
      if (adv[0]) vld_r[0] <= in_bus.valid;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) vld_r[i] <= vld_r[i-1];
      end
      if (adv[NS]) ov_r <= vld_r[NS-1];
      if (cfg_bus.valid) mode_r <= cfg_bus.mode;
    end
  end

  // stage a: magnitude, table index, range check
  logic [DW-1:0]        mag;
  logic [MW-1:0]        mag_w;
  logic [TB-1:0]        idx_nxt;
  logic signed [DW-1:0] x_a_r, g_a_r;
  logic [TB-1:0]        idx_a_r;
  logic                 neg_a_r, oor_a_r, last_a_r;

  assign mag   = in_bus.x_value[DW-1] ? DW'(-in_bus.x_value) : DW'(in_bus.x_value);
  assign mag_w = MW'(mag);

  if (SH >= 0) begin : g_idx_dn
    assign idx_nxt = mag_w[SH +: TB];
  end else begin : g_idx_up
    logic [MW-1:0] mag_up;
    assign mag_up  = mag_w << (-SH);
    assign idx_nxt = mag_up[TB-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x_a_r    <= in_bus.x_value;
      g_a_r    <= in_bus.upstream_grad;
      last_a_r <= in_bus.is_last;
      idx_a_r  <= idx_nxt;
      neg_a_r  <= in_bus.x_value[DW-1];
      oor_a_r  <= mag_w >= LIM;
    end
  end

  // stage b: table read and sign symmetry
  logic [R_W-1:0]       rom_v;
  logic [S_W-1:0]       s_nxt;
  logic [S_W-1:0]       s_b_r;
  logic signed [DW-1:0] x_b_r, g_b_r;
  logic                 last_b_r;

  assign rom_v = sig_rom[idx_a_r];

  always_comb begin
    if (oor_a_r) begin
      s_nxt = neg_a_r ? '0 : ONE;
    end else begin
      s_nxt = neg_a_r ? ONE - S_W'(rom_v) : S_W'(rom_v);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s_b_r    <= s_nxt;
      x_b_r    <= x_a_r;
      g_b_r    <= g_a_r;
      last_b_r <= last_a_r;
    end
  end

  // stage c: x*s and s*(1-s)
  logic signed [PF_W-1:0] pf_nxt;
  logic [SD_W-1:0]        sd_nxt;
  logic signed [PF_W-1:0] pf_c_r;
  logic [SD_W-1:0]        sd_c_r;
  logic [S_W-1:0]         s_c_r;
  logic signed [DW-1:0]   x_c_r, g_c_r;
  logic                   last_c_r;

  assign pf_nxt = x_b_r * $signed({1'b0, s_b_r});
  assign sd_nxt = SD_W'(s_b_r) * SD_W'(ONE - s_b_r);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      pf_c_r   <= pf_nxt;
      sd_c_r   <= sd_nxt;
      s_c_r    <= s_b_r;
      x_c_r    <= x_b_r;
      g_c_r    <= g_b_r;
      last_c_r <= last_b_r;
    end
  end

  // stage d: forward rounding, derivative s + x*s*(1-s) at full precision
  logic signed [XSD_W-1:0] xsd;
  logic signed [D_W-1:0]   d_nxt;
  logic signed [RW-1:0]    yf_rnd;
  logic signed [D_W-1:0]   d_d_r;
  logic signed [YF_W-1:0]  yf_d_r;
  logic signed [DW-1:0]    g_d_r;
  logic                    last_d_r;

  assign xsd    = x_c_r * $signed({1'b0, sd_c_r});
  assign d_nxt  = D_W'(xsd) + (D_W'(s_c_r) << (FB + 16));
  assign yf_rnd = rnd_shift(RW'(pf_c_r), 16);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      d_d_r    <= d_nxt;
      yf_d_r   <= yf_rnd[YF_W-1:0];
      g_d_r    <= g_c_r;
      last_d_r <= last_c_r;
    end
  end

  // stage e: derivative to q.16
  logic signed [RW-1:0]   dq_rnd;
  logic signed [DQ_W-1:0] dq_e_r;
  logic signed [YF_W-1:0] yf_e_r;
  logic signed [DW-1:0]   g_e_r;
  logic                   last_e_r;

  assign dq_rnd = rnd_shift(RW'(d_d_r), FB + 16);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      dq_e_r   <= dq_rnd[DQ_W-1:0];
      yf_e_r   <= yf_d_r;
      g_e_r    <= g_d_r;
      last_e_r <= last_d_r;
    end
  end

  // stage f: times the upstream gradient
  logic signed [P_W-1:0]  p_nxt;
  logic signed [P_W-1:0]  p_f_r;
  logic signed [YF_W-1:0] yf_f_r;
  logic                   last_f_r;

  assign p_nxt = dq_e_r * g_e_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      p_f_r    <= p_nxt;
      yf_f_r   <= yf_e_r;
      last_f_r <= last_e_r;
    end
  end

  // output register: final rounding, mode select, saturation
  logic signed [RW-1:0]   yg_rnd;
  logic signed [YG_W-1:0] y_sel;
  logic                   sat_nxt;
  logic [DW-1:0]          res_nxt;
  logic [DW-1:0]          res_r;
  logic                   sat_r, last_o_r;

  assign yg_rnd  = rnd_shift(RW'(p_f_r), 16);
  assign y_sel   = mode_r ? yg_rnd[YG_W-1:0] : YG_W'(yf_f_r);
  assign sat_nxt = (y_sel > MAXV) || (y_sel < MINV);

  always_comb begin
    if (sat_nxt) begin
      res_nxt = y_sel[YG_W-1] ? MINV[DW-1:0] : MAXV[DW-1:0];
    end else begin
      res_nxt = y_sel[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS]) begin
      res_r    <= res_nxt;
      sat_r    <= sat_nxt;
      last_o_r <= last_f_r;
    end
  end

  assign out_bus.valid       = ov_r;
  assign out_bus.result      = res_r;
  assign out_bus.saturated   = sat_r;
  assign out_bus.is_last_out = last_o_r;

endmodule

### hw/rtl/silu_chk.sv
`include "silu_activation_and_gradient_macros.svh"

module silu_chk #(
  parameter int DATA_WIDTH = silu_pkg::DATA_WIDTH
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] out_result,
  input logic                  out_saturated
);

  localparam logic [DATA_WIDTH-1:0] MAX_RES = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIN_RES = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // a stalled result beat stays offered
  `SILU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // and does not change under the receiver
  `SILU_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_result) && $stable(out_saturated))
  // a clipped result sits on one of the two limits
  `SILU_ASSERT_NOW(a_sat_limit, out_valid && out_saturated, out_result == MAX_RES || out_result == MIN_RES)
  // reset empties the pipeline
  `SILU_ASSERT_RESET(a_rst_empty, !out_valid)

endmodule

bind silu_activation_and_gradient silu_chk #(.DATA_WIDTH(DATA_WIDTH)) u_silu_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_result    (out_bus.result),
  .out_saturated (out_bus.saturated)
);
